### design/iso_ts_pkg.sv
`timescale 1ns / 1ps
// Package for the ISO 8601 timestamp to epoch converter.
// Holds the word types, the parse record, constants and date tables.
// Used by every module of the block; depends on nothing.
package iso_ts_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
	} chr_word_t;

	typedef struct packed {
		logic        ok;
		logic [47:0] epoch_ms;
	} res_word_t;

	typedef struct packed {
		logic        pre_ok;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [9:0]  milli;
	} rec_t;

	localparam logic [4:0] POS_SHORT = 5'd19;
	localparam logic [4:0] POS_LONG  = 5'd23;
	localparam logic [4:0] POS_LIMIT = 5'd24;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_NONE  = 8'h00;

	localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
	localparam logic [22:0] DAYS_OFFSET = 23'd719468;
	localparam logic [12:0] DIV100_MUL  = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam int          DIV100_TOP   = DIV100_SHIFT + 6;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Day of a March-based year on which the month starts.
	function automatic logic [8:0] doy_base(input logic [6:0] month);
		logic [8:0] r;
		begin
			unique case (month)
				7'd1: r = 9'd306;
				7'd2: r = 9'd337;
				7'd3: r = 9'd0;
				7'd4: r = 9'd31;
				7'd5: r = 9'd61;
				7'd6: r = 9'd92;
				7'd7: r = 9'd122;
				7'd8: r = 9'd153;
				7'd9: r = 9'd184;
				7'd10: r = 9'd214;
				7'd11: r = 9'd245;
				7'd12: r = 9'd275;
				default: r = 9'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
		logic [4:0] r;
		begin
			unique case (month)
				7'd2: r = leap ? 5'd29 : 5'd28;
				7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
				default: r = 5'd31;
			endcase
			return r;
		end
	endfunction

endpackage

### design/iso_ts_front.sv
`timescale 1ns / 1ps
// Front end: checks each character against its position and builds the fields.
// Pushes one parse record on the final character. Depends on iso_ts_pkg.
module iso_ts_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  iso_ts_pkg::chr_word_t word,
	output logic                  push,
	output iso_ts_pkg::rec_t      rec
);

	logic [4:0]  pos_q;
	logic [13:0] year_q, year_n;
	logic [6:0]  month_q, month_n, day_q, day_n, hour_q, hour_n;
	logic [6:0]  minute_q, minute_n, second_q, second_n;
	logic [9:0]  milli_q, milli_n;
	logic        fe_q;
	logic        digit, need_digit, bad_pos, err_now, len_ok;
	logic [3:0]  dval;
	logic [7:0]  sep;

	always_comb begin
		digit = (word.char_in >= iso_ts_pkg::CH_ZERO) && (word.char_in <= iso_ts_pkg::CH_NINE);
		dval = 4'(word.char_in - iso_ts_pkg::CH_ZERO);
		need_digit = 1'b0;
		bad_pos = 1'b0;
		sep = iso_ts_pkg::CH_NONE;
		year_n = year_q;
		month_n = month_q;
		day_n = day_q;
		hour_n = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		milli_n = milli_q;
		unique case (pos_q)
			5'd0, 5'd1, 5'd2, 5'd3: begin
				need_digit = 1'b1;
				if (digit) year_n = 14'({year_q, 3'b0} + {year_q, 1'b0} + 17'(dval));
			end
			5'd5, 5'd6: begin
				need_digit = 1'b1;
				if (digit) month_n = 7'({month_q, 3'b0} + {month_q, 1'b0} + 10'(dval));
			end
			5'd8, 5'd9: begin
				need_digit = 1'b1;
				if (digit) day_n = 7'({day_q, 3'b0} + {day_q, 1'b0} + 10'(dval));
			end
			5'd11, 5'd12: begin
				need_digit = 1'b1;
				if (digit) hour_n = 7'({hour_q, 3'b0} + {hour_q, 1'b0} + 10'(dval));
			end
			5'd14, 5'd15: begin
				need_digit = 1'b1;
				if (digit) minute_n = 7'({minute_q, 3'b0} + {minute_q, 1'b0} + 10'(dval));
			end
			5'd17, 5'd18: begin
				need_digit = 1'b1;
				if (digit) second_n = 7'({second_q, 3'b0} + {second_q, 1'b0} + 10'(dval));
			end
			5'd20, 5'd21, 5'd22: begin
				need_digit = 1'b1;
				if (digit) milli_n = 10'({milli_q, 3'b0} + {milli_q, 1'b0} + 13'(dval));
			end
			5'd4, 5'd7: sep = iso_ts_pkg::CH_DASH;
			5'd10: sep = iso_ts_pkg::CH_T;
			5'd13, 5'd16: sep = iso_ts_pkg::CH_COLON;
			5'd19: sep = word.is_last ? iso_ts_pkg::CH_Z : iso_ts_pkg::CH_DOT;
			5'd23: sep = iso_ts_pkg::CH_Z;
			default: bad_pos = 1'b1;
		endcase
		err_now = bad_pos || (need_digit && !digit) ||
			((sep != iso_ts_pkg::CH_NONE) && (word.char_in != sep));
		len_ok = (pos_q == iso_ts_pkg::POS_SHORT) || (pos_q == iso_ts_pkg::POS_LONG);

		rec.pre_ok = !(fe_q || err_now) && len_ok && (year_n >= iso_ts_pkg::EPOCH_YEAR) &&
			(month_n >= 7'd1) && (month_n <= 7'd12) && (day_n >= 7'd1) &&
			(hour_n <= 7'd23) && (minute_n <= 7'd59) && (second_n <= 7'd59);
		rec.year = year_n;
		rec.month = month_n;
		rec.day = day_n;
		rec.hour = hour_n;
		rec.minute = minute_n;
		rec.second = second_n;
		rec.milli = milli_n;
		push = accept && word.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			milli_q <= '0;
			fe_q <= 1'b0;
		end else if (accept) begin
			if (word.is_last) begin
				pos_q <= '0;
				year_q <= '0;
				month_q <= '0;
				day_q <= '0;
				hour_q <= '0;
				minute_q <= '0;
				second_q <= '0;
				milli_q <= '0;
				fe_q <= 1'b0;
			end else begin
				if (pos_q < iso_ts_pkg::POS_LIMIT) pos_q <= pos_q + 5'd1;
				year_q <= year_n;
				month_q <= month_n;
				day_q <= day_n;
				hour_q <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				milli_q <= milli_n;
				fe_q <= fe_q || err_now;
			end
		end
	end

endmodule

### design/iso_ts_queue.sv
`timescale 1ns / 1ps
// Short queue of parse records between the front end and the converter.
// Depends on iso_ts_pkg for the record type and depth.
module iso_ts_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  iso_ts_pkg::rec_t push_rec,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output iso_ts_pkg::rec_t head
);

	iso_ts_pkg::rec_t mem_q [iso_ts_pkg::QUEUE_DEPTH];
	logic [iso_ts_pkg::QUEUE_AW-1:0] wr_q, rd_q;
	logic [iso_ts_pkg::QUEUE_AW:0]   cnt_q;
	logic                            do_push, do_pop;

	assign full = (cnt_q == (iso_ts_pkg::QUEUE_AW+1)'(iso_ts_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### design/iso_ts_back.sv
`timescale 1ns / 1ps
// Converter: checks the day against the month length and turns the date into epoch ms.
// Runs a short sequence of steps per record. Depends on iso_ts_pkg.
module iso_ts_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	input  iso_ts_pkg::rec_t      rec,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_stall,
	output iso_ts_pkg::res_word_t res_word
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_QUOT = 6'b000010,
		ST_DAYS = 6'b000100,
		ST_SECS = 6'b001000,
		ST_MSEC = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t           state_q;
	iso_ts_pkg::rec_t rec_q;
	logic [13:0]      yy_q, yy;
	logic [6:0]       qy_q, qyy_q;
	logic [26:0]      prod_y, prod_yy;
	logic [13:0]      rem_y;
	logic             leap, ok_n, ok_q;
	logic [22:0]      days_sum;
	logic [21:0]      days_q;
	logic [16:0]      tod_n, tod_q;
	logic [37:0]      secs_q;
	logic [47:0]      ms;
	iso_ts_pkg::res_word_t out_q;

	always_comb begin
		yy = rec_q.year - 14'(rec_q.month <= 7'd2);
		prod_y = 27'(rec_q.year) * 27'(iso_ts_pkg::DIV100_MUL);
		prod_yy = 27'(yy) * 27'(iso_ts_pkg::DIV100_MUL);

		rem_y = rec_q.year - 14'(21'(qy_q) * 21'd100);
		leap = (rec_q.year[1:0] == 2'b00) && ((rem_y != '0) || (qy_q[1:0] == 2'b00));
		ok_n = rec_q.pre_ok && (rec_q.day <= 7'(iso_ts_pkg::month_len(rec_q.month, leap)));
		days_sum = 23'(yy_q * 23'd365) + 23'(yy_q >> 2) - 23'(qyy_q) + 23'(qyy_q >> 2)
			+ 23'(iso_ts_pkg::doy_base(rec_q.month)) + 23'(rec_q.day) - 23'd1
			- iso_ts_pkg::DAYS_OFFSET;
		tod_n = 17'(rec_q.hour * 17'd3600) + 17'(rec_q.minute * 17'd60) + 17'(rec_q.second);

		ms = {secs_q, 10'b0} - 48'({secs_q, 4'b0}) - 48'({secs_q, 3'b0}) + 48'(rec_q.milli);

		pop = (state_q == ST_IDLE) && rec_valid;
		res_valid = (state_q == ST_OUT);
		res_word = out_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (rec_valid) rec_q <= rec;
			ST_QUOT: begin
				yy_q <= yy;
				qy_q <= prod_y[iso_ts_pkg::DIV100_TOP:iso_ts_pkg::DIV100_SHIFT];
				qyy_q <= prod_yy[iso_ts_pkg::DIV100_TOP:iso_ts_pkg::DIV100_SHIFT];
			end
			ST_DAYS: begin
				days_q <= 22'(days_sum);
				tod_q <= tod_n;
			end
			ST_SECS: secs_q <= 38'(39'(days_q) * 39'(iso_ts_pkg::SEC_PER_DAY)) + 38'(tod_q);
			ST_MSEC: begin
				out_q.ok <= ok_q;
				out_q.epoch_ms <= ok_q ? ms : '0;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (rec_valid) state_q <= ST_QUOT;
				ST_QUOT: state_q <= ST_DAYS;
				ST_DAYS: begin
					ok_q <= ok_n;
					state_q <= ST_SECS;
				end
				ST_SECS: state_q <= ST_MSEC;
				ST_MSEC: state_q <= ST_OUT;
				ST_OUT: if (!res_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/iso8601_timestamp_to_epoch.sv
`timescale 1ns / 1ps
// Top level of the ISO 8601 UTC timestamp to epoch milliseconds converter.
// Instantiates iso_ts_front, iso_ts_queue and iso_ts_back; depends on iso_ts_pkg.
//
// channel | dir | handshake            | word
// chr     | in  | chr_valid/chr_stall  | char_in, is_last
// res     | out | res_valid/res_stall  | ok, epoch_ms
//
// Characters are taken one per cycle while the record queue has room.
// The final character pushes a record; the converter takes one record at a
// time through its quotient, days, seconds and milliseconds states, then holds
// the result until it is taken; that sequence holds the sustained string rate.
// Reset clears the parser position and accumulators, the queue and the converter.
// The queue holds two records, so parsing goes on while a result is stalled.
module iso8601_timestamp_to_epoch (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  chr_valid,
	output logic                  chr_stall,
	input  iso_ts_pkg::chr_word_t chr_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output iso_ts_pkg::res_word_t res_word
);

	logic             accept, push, pop, full, not_empty;
	iso_ts_pkg::rec_t push_rec, head;

	assign chr_stall = full;
	assign accept = chr_valid && !full;

	iso_ts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.word   (chr_word),
		.push   (push),
		.rec    (push_rec)
	);

	iso_ts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	iso_ts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (not_empty),
		.rec       (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

`ifndef SYNTH
	a_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.ok |-> res_word.epoch_ms == 48'd0)
		else $error("epoch_ms not zero on a rejected timestamp");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.ok |-> res_word.epoch_ms < 48'd253402300800000)
		else $error("epoch_ms beyond the year 9999");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall |=> !res_valid)
		else $error("result shown again right after it was taken");
`endif

endmodule
